// ===== hw/rtl/mstm_pkg.sv =====
package mstm_pkg;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_ADDED   = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_DELETED = 2'd2;
    localparam logic [1:0] KIND_FIRED   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] now_ms;
        logic [30:0] period_ms;
        logic        repeat_req;
        logic [31:0] target_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] timer_id;
        logic [31:0] latest_id;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_DEL,
        OP_TSTART,
        OP_FIRE,
        OP_TEND
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [47:0] now_ms;
        logic [30:0] period_ms;
        logic        repeat_req;
        logic        clr_pend;
    } t_ctl;

endpackage

// ===== hw/rtl/mstm_cell.sv =====
module mstm_cell #(
    parameter int IDX_W    = 4,
    parameter int SLOT_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mstm_pkg::t_ctl     i_ctl,
    input  logic               i_sel,
    input  logic               i_cand_v,
    input  logic [31:0]        i_cand_id,
    input  logic [IDX_W-1:0]   i_cand_idx,
    output logic               o_cand_v,
    output logic [31:0]        o_cand_id,
    output logic [IDX_W-1:0]   o_cand_idx,
    output logic               o_valid,
    output logic               o_match
);
    logic              r_valid;
    logic              r_pend;
    logic              r_due;
    logic [31:0]       r_id;
    logic [48:0]       r_wake;
    logic [30:0]       r_period;
    logic              r_rep;
    logic              r_cv;
    logic [31:0]       r_cid;
    logic [IDX_W-1:0]  r_cidx;
    logic [48:0]       w_reload;
    logic              w_take;

    assign w_reload = {1'b0, i_ctl.now_ms} + {18'd0, i_ctl.period_ms};
    assign o_valid  = r_valid;
    assign o_match  = r_valid && (r_id == i_ctl.key);
    assign w_take   = r_due && (!i_cand_v || (r_id < i_cand_id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_due   <= 1'b0;
            r_cv    <= 1'b0;
        end else begin
            r_cv <= w_take || i_cand_v;
            unique case (i_ctl.op)
                mstm_pkg::OP_ADD: begin
                    if (i_sel) begin
                        r_valid <= 1'b1;
                        if (i_ctl.clr_pend) begin
                            r_pend <= 1'b0;
                        end
                    end
                end
                mstm_pkg::OP_DEL: begin
                    if (o_match) begin
                        r_pend <= 1'b1;
                    end
                end
                mstm_pkg::OP_TSTART: begin
                    r_due <= r_valid && (r_wake <= {1'b0, i_ctl.now_ms});
                end
                mstm_pkg::OP_FIRE: begin
                    if (i_sel) begin
                        r_due <= 1'b0;
                        if (!r_rep) begin
                            r_pend <= 1'b1;
                        end
                    end
                end
                mstm_pkg::OP_TEND: begin
                    if (r_pend) begin
                        r_valid <= 1'b0;
                        r_pend  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cid  <= r_id;
            r_cidx <= IDX_W'(SLOT_IDX);
        end else begin
            r_cid  <= i_cand_id;
            r_cidx <= i_cand_idx;
        end
        if (i_ctl.op == mstm_pkg::OP_ADD && i_sel) begin
            r_id     <= i_ctl.key;
            r_wake   <= w_reload;
            r_period <= i_ctl.period_ms;
            r_rep    <= i_ctl.repeat_req;
        end else if (i_ctl.op == mstm_pkg::OP_FIRE && i_sel && r_rep) begin
            r_wake <= {1'b0, i_ctl.now_ms} + {18'd0, r_period};
        end
    end

    assign o_cand_v   = r_cv;
    assign o_cand_id  = r_cid;
    assign o_cand_idx = r_cidx;

endmodule

// ===== hw/rtl/multi_slot_timer_manager.sv =====
// timer slot table with add, delete and tick commands
// input channel: i_in_valid / o_in_stall carrying one command item
// output channel: o_out_valid / i_out_stall carrying result items
// one item is taken at a time; o_in_stall is high until all its results
// have been loaded into the output register
// add and delete: one result, loaded from the exec state once the output is free
// tick: a due-timer minimum search runs down the chain of slot cells,
// one cell per cycle, and each fired timer takes a full pass of the
// chain before the next search starts
// fired ids come out in ascending id order, the final one with last set
// a tick with nothing due gives no result
// reset empties the table and clears the id counter
// a stall on the output holds the result register and pauses the block once it has a result to load
module multi_slot_timer_manager #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mstm_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mstm_pkg::t_out_item   o_out_item
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_SWEEP = 3'b100
    } t_state;

    t_state               r_state, n_state;
    mstm_pkg::t_in_item   r_in;
    logic [31:0]          r_ctr, n_ctr;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_have, n_have;
    logic [31:0]          r_held, n_held;
    logic                 r_ov;
    mstm_pkg::t_out_item  r_out, n_out;
    logic                 w_out_we;
    logic                 w_out_free;
    mstm_pkg::t_ctl       w_ctl;
    logic [SLOTS-1:0]     w_sel;
    logic [SLOTS-1:0]     w_valid;
    logic [SLOTS-1:0]     w_match;
    logic [SLOTS-1:0]     w_free;
    logic [SLOTS-1:0]     w_first_free;
    logic [SLOTS-1:0]     w_fire_sel;
    logic [31:0]          w_next;
    logic                 w_cv  [SLOTS+1];
    logic [31:0]          w_cid [SLOTS+1];
    logic [IDX_W-1:0]     w_cidx[SLOTS+1];

    assign w_cv[0]   = 1'b0;
    assign w_cid[0]  = '0;
    assign w_cidx[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        mstm_cell #(
            .IDX_W    (IDX_W),
            .SLOT_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_sel      (w_sel[g]),
            .i_cand_v   (w_cv[g]),
            .i_cand_id  (w_cid[g]),
            .i_cand_idx (w_cidx[g]),
            .o_cand_v   (w_cv[g+1]),
            .o_cand_id  (w_cid[g+1]),
            .o_cand_idx (w_cidx[g+1]),
            .o_valid    (w_valid[g]),
            .o_match    (w_match[g])
        );
        assign w_fire_sel[g] = (w_cidx[SLOTS] == IDX_W'(g));
    end

    assign w_next       = (r_ctr == 32'hFFFF_FFFF) ? 32'd1 : r_ctr + 32'd1;
    assign w_free       = ~w_valid;
    assign w_first_free = w_free & (~w_free + SLOTS'(1));
    assign w_out_free   = !r_ov || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_out_item   = r_out;

    always_comb begin
        n_state          = r_state;
        n_ctr            = r_ctr;
        n_cnt            = r_cnt;
        n_have           = r_have;
        n_held           = r_held;
        n_out            = r_out;
        w_out_we         = 1'b0;
        w_sel            = '0;
        w_ctl.op         = mstm_pkg::OP_NONE;
        w_ctl.key        = (r_in.cmd == mstm_pkg::CMD_ADD) ? w_next : r_in.target_id;
        w_ctl.now_ms     = r_in.now_ms;
        w_ctl.period_ms  = r_in.period_ms;
        w_ctl.repeat_req = r_in.repeat_req;
        w_ctl.clr_pend   = !(|w_match);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_in.cmd)
                    mstm_pkg::CMD_ADD: begin
                        if (w_out_free) begin
                            w_out_we        = 1'b1;
                            n_out.last      = 1'b1;
                            n_state         = S_IDLE;
                            if (|w_match || |w_free) begin
                                w_ctl.op        = mstm_pkg::OP_ADD;
                                w_sel           = (|w_match) ? w_match : w_first_free;
                                n_ctr           = w_next;
                                n_out.kind      = mstm_pkg::KIND_ADDED;
                                n_out.timer_id  = w_next;
                                n_out.latest_id = w_next;
                            end else begin
                                n_out.kind      = mstm_pkg::KIND_FULL;
                                n_out.timer_id  = '0;
                                n_out.latest_id = r_ctr;
                            end
                        end
                    end
                    mstm_pkg::CMD_DEL: begin
                        if (w_out_free) begin
                            w_ctl.op        = mstm_pkg::OP_DEL;
                            w_out_we        = 1'b1;
                            n_out.kind      = mstm_pkg::KIND_DELETED;
                            n_out.timer_id  = r_in.target_id;
                            n_out.latest_id = r_ctr;
                            n_out.last      = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                    mstm_pkg::CMD_TICK: begin
                        w_ctl.op = mstm_pkg::OP_TSTART;
                        n_cnt    = '0;
                        n_have   = 1'b0;
                        n_state  = S_SWEEP;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SWEEP: begin
                if (r_cnt != CNT_W'(SLOTS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_have || w_out_free) begin
                    if (r_have) begin
                        w_out_we        = 1'b1;
                        n_out.kind      = mstm_pkg::KIND_FIRED;
                        n_out.timer_id  = r_held;
                        n_out.latest_id = r_ctr;
                        n_out.last      = !w_cv[SLOTS];
                    end
                    if (w_cv[SLOTS]) begin
                        w_ctl.op = mstm_pkg::OP_FIRE;
                        w_sel    = w_fire_sel;
                        n_held   = w_cid[SLOTS];
                        n_have   = 1'b1;
                        n_cnt    = '0;
                    end else begin
                        w_ctl.op = mstm_pkg::OP_TEND;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctr   <= '0;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_cnt   <= n_cnt;
            r_have  <= n_have;
            if (w_out_we) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_item;
        end
        r_held <= n_held;
        if (w_out_we) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("several slots hold the same id");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOTS))
        else $error("sweep counter out of range");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_we && n_out.last |=> r_state == S_IDLE)
        else $error("block busy after final result of an item");
    a_full_keeps_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_we && n_out.kind == mstm_pkg::KIND_FULL |=> r_ctr == $past(r_ctr))
        else $error("id counter moved on a refused add");
`endif

endmodule

// ===== tb/sv/tb_multi_slot_timer_manager.sv =====
`timescale 1ns / 1ps

module tb_multi_slot_timer_manager;

    localparam int NSLOT = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int IN_W = $bits(mstm_pkg::t_in_item);
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    mstm_pkg::t_in_item   i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    mstm_pkg::t_out_item  o_out_item;

    multi_slot_timer_manager #(.SLOTS(NSLOT)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_id [NSLOT];
    logic [48:0] tbl_wake [NSLOT];
    logic [30:0] tbl_period [NSLOT];
    logic        tbl_repeat [NSLOT];
    logic        tbl_pend [NSLOT];
    logic [31:0] id_ctr;

    mstm_pkg::t_out_item expected_results[$];
    int          error_count;
    int          idle_cycles;
    bit          calm;
    logic [47:0] clock_ms;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(input string what, input mstm_pkg::t_out_item got,
                          input mstm_pkg::t_out_item exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        error_count++;
    endtask

    task automatic queue_result(input mstm_pkg::t_out_item r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic mstm_pkg::t_out_item make_result(logic [1:0] kind, logic [31:0] id,
                                                        logic last);
        mstm_pkg::t_out_item r;
        r.kind = kind;
        r.timer_id = id;
        r.latest_id = id_ctr;
        r.last = last;
        return r;
    endfunction

    task automatic predict_command(input mstm_pkg::t_in_item it);
        int slot;
        int pick;
        int n;
        logic [31:0] nxt;
        logic due [NSLOT];
        mstm_pkg::t_out_item fired [NSLOT];
        slot = -1;
        case (it.cmd)
            mstm_pkg::CMD_ADD: begin
                nxt = id_ctr + 1;
                if (nxt == 0) nxt = 1;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && tbl_id[i] == nxt) slot = i;
                if (slot < 0) begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!tbl_valid[i]) slot = i;
                    if (slot >= 0) tbl_pend[slot] = 1'b0;
                end
                if (slot < 0) begin
                    queue_result(make_result(mstm_pkg::KIND_FULL, 32'd0, 1'b1));
                end else begin
                    id_ctr = nxt;
                    tbl_valid[slot] = 1'b1;
                    tbl_id[slot] = nxt;
                    tbl_wake[slot] = {1'b0, it.now_ms} + 49'(it.period_ms);
                    tbl_period[slot] = it.period_ms;
                    tbl_repeat[slot] = it.repeat_req;
                    queue_result(make_result(mstm_pkg::KIND_ADDED, nxt, 1'b1));
                end
            end
            mstm_pkg::CMD_DEL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && tbl_id[i] == it.target_id) tbl_pend[i] = 1'b1;
                queue_result(make_result(mstm_pkg::KIND_DELETED, it.target_id, 1'b1));
            end
            mstm_pkg::CMD_TICK: begin
                for (int i = 0; i < NSLOT; i++)
                    due[i] = tbl_valid[i] && tbl_wake[i] <= {1'b0, it.now_ms};
                n = 0;
                forever begin
                    pick = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (due[i] && (pick < 0 || tbl_id[i] < tbl_id[pick])) pick = i;
                    if (pick < 0) break;
                    due[pick] = 1'b0;
                    fired[n] = make_result(mstm_pkg::KIND_FIRED, tbl_id[pick], 1'b0);
                    n++;
                    if (tbl_repeat[pick])
                        tbl_wake[pick] = {1'b0, it.now_ms} + 49'(tbl_period[pick]);
                    else
                        tbl_pend[pick] = 1'b1;
                end
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_pend[i]) begin
                        tbl_valid[i] = 1'b0;
                        tbl_pend[i] = 1'b0;
                    end
                if (n > 0) fired[n - 1].last = 1'b1;
                for (int k = 0; k < n; k++) queue_result(fired[k]);
            end
            default: begin
            end
        endcase
    endtask

    // sends one item, with an optional random gap first
    task automatic send_item(input mstm_pkg::t_in_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_command(it);
        @(negedge i_clk);
    endtask

    task automatic send_add(input logic [47:0] now, input logic [30:0] per, input logic rep);
        mstm_pkg::t_in_item it;
        it = '0;
        it.cmd = mstm_pkg::CMD_ADD;
        it.now_ms = now;
        it.period_ms = per;
        it.repeat_req = rep;
        it.target_id = $urandom;
        send_item(it);
    endtask

    task automatic send_del(input logic [31:0] id);
        mstm_pkg::t_in_item it;
        it = '0;
        it.cmd = mstm_pkg::CMD_DEL;
        it.target_id = id;
        it.now_ms = 48'({$urandom, $urandom});
        it.period_ms = 31'($urandom);
        send_item(it);
    endtask

    task automatic send_tick(input logic [47:0] now);
        mstm_pkg::t_in_item it;
        it = '0;
        it.cmd = mstm_pkg::CMD_TICK;
        it.now_ms = now;
        it.period_ms = 31'($urandom);
        it.repeat_req = 1'($urandom);
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() > 0) @(negedge i_clk);
        repeat (3 * (NSLOT + 1) + 10) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        mstm_pkg::t_out_item exp;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", o_out_item, '0);
                end else begin
                    exp = expected_results.pop_front();
                    if (o_out_item.kind != exp.kind) report("kind", o_out_item, exp);
                    if (o_out_item.timer_id != exp.timer_id) report("timer_id", o_out_item, exp);
                    if (o_out_item.latest_id != exp.latest_id)
                        report("latest_id", o_out_item, exp);
                    if (o_out_item.last != exp.last) report("last", o_out_item, exp);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired");
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_extremes();
        send_tick(48'd0);
        send_add(48'd0, 31'd0, 1'b0);
        send_add(48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_add(48'd100, 31'd50, 1'b1);
        send_tick(48'd99);
        send_tick(48'd150);
        send_tick(48'hFFFF_FFFF_FFFF);
        send_del(32'hFFFF_FFFF);
        send_del(32'd0);
        send_del(32'd3);
        send_del(32'd3);
        send_tick(48'hFFFF_FFFF_FFFF);
        begin
            mstm_pkg::t_in_item it;
            it = '1;
            it.cmd = CMD_NOP;
            send_item(it);
        end
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT + 2; i++) send_add(48'd1000, 31'(i), i[0]);
        send_del(id_ctr);
        send_add(48'd1000, 31'd5, 1'b0);
        send_tick(48'd2000);
        send_tick(48'hFFFF_FFFF_FFFF);
        drain();
    endtask

    // empty the table, then refill it with mixed short timers
    task automatic test_id_wrap();
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i]) send_del(tbl_id[i]);
        send_tick(48'd0);
        drain();
        for (int k = 0; k < 3; k++) send_add(48'd500, 31'd1000, 1'b1);
        send_del(id_ctr);
        // interleave adds and ticks around the due times
        for (int k = 0; k < 8; k++) begin
            send_add(48'd600, 31'($urandom_range(0, 20)), 1'($urandom));
            send_tick(48'($urandom_range(500, 700)));
        end
        drain();
    endtask

    task automatic test_random();
        int pick;
        clock_ms = 48'($urandom_range(0, 1000));
        for (int n = 0; n < 200; n++) begin
            if (n > 160) calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                if ($urandom_range(0, 19) == 0)
                    send_add(48'({$urandom, $urandom}), 31'($urandom), 1'($urandom));
                else
                    send_add(clock_ms, 31'($urandom_range(0, 300)), 1'($urandom));
            end else if (pick < 6) begin
                if ($urandom_range(0, 4) == 0)
                    send_del($urandom);
                else
                    send_del(id_ctr - 32'($urandom_range(0, NSLOT)));
            end else if (pick < 9) begin
                clock_ms = clock_ms + 48'($urandom_range(0, 150));
                send_tick(clock_ms);
            end else if ($urandom_range(0, 3) == 0) begin
                send_tick(48'({$urandom, $urandom}));
            end else begin
                mstm_pkg::t_in_item it;
                it = IN_W'({$urandom, $urandom, $urandom, $urandom});
                it.cmd = CMD_NOP;
                send_item(it);
            end
        end
        drain();
    endtask

    initial begin
        error_count = 0;
        calm = 1'b0;
        id_ctr = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_pend[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_wake[i] = '0;
            tbl_period[i] = '0;
            tbl_repeat[i] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_full_table();
        test_id_wrap();
        test_random();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (expected_results.size() != 0)
                $display("%0d results never arrived", expected_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
